>>> rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the comment-skipping tokenizer
// scan modes, token codes, character constants and the per-byte result bundle
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int TOKEN_CAP_MAX = 1024;
  localparam int CAP_W         = 11;
  localparam int LEN_W         = $clog2(TOKEN_CAP_MAX + 1);

  localparam logic [CAP_W-1:0] TOKEN_CAP_RESET = CAP_W'(TOKEN_CAP_MAX);

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;

  typedef enum logic [2:0] {
    MODE_SKIP   = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4,
    MODE_STRING = 3'd5,
    MODE_WORD   = 3'd6,
    MODE_DRAIN  = 3'd7
  } scan_mode_t;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STRING = 1'b1
  } token_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_TRUNC   = 2'd1,
    STATUS_DISCARD = 2'd2
  } token_status_t;

  // all results caused by one byte: up to two token bytes, then an optional
  // closing record (token end and/or buffer end)
  typedef struct packed {
    logic [1:0]    nchars;
    logic [7:0]    char0;
    logic [7:0]    char1;
    logic          has_end;
    logic          end_done;
    token_kind_t   end_kind;
    token_status_t end_status;
    logic          end_sdone;
  } bundle_t;

  // clamp the programmed cap to 1..TOKEN_CAP_MAX
  function automatic logic [LEN_W-1:0] cap_in_use(input logic [CAP_W-1:0] cap);
    logic [LEN_W-1:0] c;
    if (cap == '0) begin
      c = LEN_W'(1);
    end else if (int'(cap) > TOKEN_CAP_MAX) begin
      c = LEN_W'(TOKEN_CAP_MAX);
    end else begin
      c = LEN_W'(cap);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/comment_skipping_tokenizer.sv
// ----------------------------------------------------------------------------
// comment_skipping_tokenizer: byte-serial token parser with comment skipping
// streams token bytes and end-of-token records out of a text byte stream
// ----------------------------------------------------------------------------
// usage
//   input request: one text byte (text_byte) on in_valid / in_stall; a zero
//     byte ends the buffer and rearms the parser for the next one
//   output request: one result (token byte, or end-of-token / end-of-buffer
//     record) on out_valid / out_stall; last_of_run marks the final result
//     caused by one input byte
//   cfg_wr_en / cfg_wr_data load token_cap; write it only while idle
// latency and throughput
//   each accepted byte is parsed in the cycle it is taken; its results show
//   on the output from the next cycle on
//   one byte per cycle while every byte gives at most one result and
//   out_stall stays low; a byte that gives two or three results holds the
//   output port until all of them are taken; a two-entry result queue sets
//   the limit: in_stall rises only when both entries hold results not yet taken
// reset
//   parser between tokens, token_cap = 1024, result queue empty
// receiver stall
//   the head result holds steady; parsing goes on until the queue is full
// ----------------------------------------------------------------------------
module comment_skipping_tokenizer (
  input  logic                     clk,
  input  logic                     rst,
  // config
  input  logic                     cfg_wr_en,
  input  logic [cst_pkg::CAP_W-1:0] cfg_wr_data,
  // input request
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               text_byte,
  // output request
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               token_char,
  output logic                     char_valid,
  output logic                     token_done,
  output logic                     token_kind,
  output logic [1:0]               token_status,
  output logic                     stream_done,
  output logic                     last_of_run
);

  // configuration
  logic [cst_pkg::CAP_W-1:0] token_cap;
  logic [cst_pkg::LEN_W-1:0] cap_use;

  // parser state
  cst_pkg::scan_mode_t       scan_mode, scan_mode_next;
  logic [cst_pkg::LEN_W-1:0] token_length, token_length_next;
  logic                      overflow_seen, overflow_seen_next;

  // per-byte result bundle
  cst_pkg::bundle_t          bnd;
  logic [cst_pkg::LEN_W-1:0] len_plus1;
  logic [cst_pkg::LEN_W-1:0] len_plus2;
  logic                      is_ws;   // zero and all bytes up to space
  logic                      in_accept;
  logic                      push;

  // result queue: two bundles plus a walk index into the head bundle
  cst_pkg::bundle_t          queue [2];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic [1:0]                q_count;
  logic [1:0]                sub_idx;
  cst_pkg::bundle_t          head;
  logic [1:0]                head_total;
  logic                      head_last;
  logic                      out_accept;
  logic                      pop;

  assign cap_use   = cst_pkg::cap_in_use(token_cap);
  assign in_stall  = (q_count == 2'd2);
  assign in_accept = in_valid && !in_stall;
  assign is_ws     = (text_byte <= cst_pkg::CH_SPACE);
  assign len_plus1 = token_length + cst_pkg::LEN_W'(1);
  assign len_plus2 = cst_pkg::LEN_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_cap <= cst_pkg::TOKEN_CAP_RESET;
    end else if (cfg_wr_en) begin
      token_cap <= cfg_wr_data;
    end
  end

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= cst_pkg::MODE_SKIP;
      token_length  <= '0;
      overflow_seen <= 1'b0;
    end else if (in_accept) begin
      scan_mode     <= scan_mode_next;
      token_length  <= token_length_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // next mode and result bundle for the byte on the input
  always_comb begin
    scan_mode_next     = scan_mode;
    token_length_next  = token_length;
    overflow_seen_next = overflow_seen;
    bnd                = '0;
    bnd.end_kind       = cst_pkg::KIND_WORD;
    bnd.end_status     = cst_pkg::STATUS_OK;

    unique case (scan_mode)
      cst_pkg::MODE_SKIP: begin
        if (text_byte == cst_pkg::CH_NUL) begin
          bnd.has_end   = 1'b1;
          bnd.end_sdone = 1'b1;
        end else if (is_ws) begin
          // whitespace between tokens
        end else if (text_byte == cst_pkg::CH_SLASH) begin
          scan_mode_next = cst_pkg::MODE_SLASH;
        end else if (text_byte == cst_pkg::CH_QUOTE) begin
          scan_mode_next     = cst_pkg::MODE_STRING;
          token_length_next  = '0;
          overflow_seen_next = 1'b0;
        end else begin
          // first byte of a word
          bnd.nchars         = 2'd1;
          bnd.char0          = text_byte;
          token_length_next  = cst_pkg::LEN_W'(1);
          overflow_seen_next = 1'b0;
          if (cap_use == cst_pkg::LEN_W'(1)) begin
            bnd.has_end    = 1'b1;
            bnd.end_done   = 1'b1;
            bnd.end_status = cst_pkg::STATUS_DISCARD;
            bnd.end_sdone  = 1'b1;
            scan_mode_next = cst_pkg::MODE_DRAIN;
          end else begin
            scan_mode_next = cst_pkg::MODE_WORD;
          end
        end
      end

      cst_pkg::MODE_SLASH: begin
        if (text_byte == cst_pkg::CH_SLASH) begin
          scan_mode_next = cst_pkg::MODE_LINE;
        end else if (text_byte == cst_pkg::CH_STAR) begin
          scan_mode_next = cst_pkg::MODE_BLOCK;
        end else begin
          // lone slash opens a word
          bnd.nchars         = 2'd1;
          bnd.char0          = cst_pkg::CH_SLASH;
          token_length_next  = cst_pkg::LEN_W'(1);
          overflow_seen_next = 1'b0;
          if (cap_use == cst_pkg::LEN_W'(1)) begin
            bnd.has_end    = 1'b1;
            bnd.end_done   = 1'b1;
            bnd.end_status = cst_pkg::STATUS_DISCARD;
            bnd.end_sdone  = 1'b1;
            scan_mode_next = (text_byte == cst_pkg::CH_NUL) ? cst_pkg::MODE_SKIP
                                                            : cst_pkg::MODE_DRAIN;
          end else if (text_byte == cst_pkg::CH_NUL) begin
            bnd.has_end    = 1'b1;
            bnd.end_done   = 1'b1;
            bnd.end_sdone  = 1'b1;
            scan_mode_next = cst_pkg::MODE_SKIP;
          end else if (is_ws) begin
            bnd.has_end    = 1'b1;
            bnd.end_done   = 1'b1;
            scan_mode_next = cst_pkg::MODE_SKIP;
          end else begin
            // this byte is the word's second one
            bnd.nchars        = 2'd2;
            bnd.char1         = text_byte;
            token_length_next = len_plus2;
            if (len_plus2 >= cap_use) begin
              bnd.has_end    = 1'b1;
              bnd.end_done   = 1'b1;
              bnd.end_status = cst_pkg::STATUS_DISCARD;
              bnd.end_sdone  = 1'b1;
              scan_mode_next = cst_pkg::MODE_DRAIN;
            end else begin
              scan_mode_next = cst_pkg::MODE_WORD;
            end
          end
        end
      end

      cst_pkg::MODE_LINE: begin
        if (text_byte == cst_pkg::CH_NUL) begin
          bnd.has_end    = 1'b1;
          bnd.end_sdone  = 1'b1;
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else if (text_byte == cst_pkg::CH_NEWLINE) begin
          scan_mode_next = cst_pkg::MODE_SKIP;
        end
      end

      cst_pkg::MODE_BLOCK: begin
        if (text_byte == cst_pkg::CH_NUL) begin
          bnd.has_end    = 1'b1;
          bnd.end_sdone  = 1'b1;
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else if (text_byte == cst_pkg::CH_STAR) begin
          scan_mode_next = cst_pkg::MODE_STAR;
        end
      end

      cst_pkg::MODE_STAR: begin
        if (text_byte == cst_pkg::CH_NUL) begin
          bnd.has_end    = 1'b1;
          bnd.end_sdone  = 1'b1;
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else if (text_byte == cst_pkg::CH_SLASH) begin
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else if (text_byte != cst_pkg::CH_STAR) begin
          scan_mode_next = cst_pkg::MODE_BLOCK;
        end
      end

      cst_pkg::MODE_STRING: begin
        if (text_byte == cst_pkg::CH_NUL || text_byte == cst_pkg::CH_QUOTE) begin
          bnd.has_end    = 1'b1;
          bnd.end_done   = 1'b1;
          bnd.end_kind   = cst_pkg::KIND_STRING;
          bnd.end_status = overflow_seen ? cst_pkg::STATUS_TRUNC : cst_pkg::STATUS_OK;
          bnd.end_sdone  = (text_byte == cst_pkg::CH_NUL);
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else if (token_length < cap_use) begin
          bnd.nchars        = 2'd1;
          bnd.char0         = text_byte;
          token_length_next = len_plus1;
        end else begin
          // past the cap: drop the byte, flag truncation
          overflow_seen_next = 1'b1;
        end
      end

      cst_pkg::MODE_WORD: begin
        if (text_byte == cst_pkg::CH_NUL) begin
          bnd.has_end    = 1'b1;
          bnd.end_done   = 1'b1;
          bnd.end_sdone  = 1'b1;
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else if (is_ws) begin
          bnd.has_end    = 1'b1;
          bnd.end_done   = 1'b1;
          scan_mode_next = cst_pkg::MODE_SKIP;
        end else begin
          bnd.nchars        = 2'd1;
          bnd.char0         = text_byte;
          token_length_next = len_plus1;
          if (len_plus1 >= cap_use) begin
            bnd.has_end    = 1'b1;
            bnd.end_done   = 1'b1;
            bnd.end_status = cst_pkg::STATUS_DISCARD;
            bnd.end_sdone  = 1'b1;
            scan_mode_next = cst_pkg::MODE_DRAIN;
          end
        end
      end

      cst_pkg::MODE_DRAIN: begin
        // parsing ended: swallow bytes up to the buffer end
        if (text_byte == cst_pkg::CH_NUL) begin
          scan_mode_next = cst_pkg::MODE_SKIP;
        end
      end
    endcase
  end

  // bytes that cause no result never enter the queue
  assign push = in_accept && ((bnd.nchars != 2'd0) || bnd.has_end);

  // head of the queue and the result it shows
  assign head       = queue[rd_ptr];
  assign head_total = 2'(head.nchars + {1'b0, head.has_end});
  assign head_last  = (sub_idx == 2'(head_total - 2'd1));
  assign out_valid  = (q_count != 2'd0);
  assign out_accept = out_valid && !out_stall;
  assign pop        = out_accept && head_last;

  always_comb begin
    token_char   = '0;
    char_valid   = 1'b0;
    token_done   = 1'b0;
    token_kind   = 1'b0;
    token_status = '0;
    stream_done  = 1'b0;
    last_of_run  = head_last;
    if (sub_idx < head.nchars) begin
      token_char = (sub_idx == 2'd0) ? head.char0 : head.char1;
      char_valid = 1'b1;
    end else begin
      token_done   = head.end_done;
      token_kind   = head.end_kind;
      token_status = head.end_status;
      stream_done  = head.end_sdone;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= bnd;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= '0;
      sub_idx <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr  <= !rd_ptr;
        sub_idx <= '0;
      end else if (out_accept) begin
        sub_idx <= sub_idx + 2'd1;
      end
      if (push && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !push) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker: port-level checks for the comment-skipping tokenizer
// watches the output request stream for malformed results
// ----------------------------------------------------------------------------
module cst_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       char_valid,
  input logic       token_done,
  input logic       token_kind,
  input logic [1:0] token_status,
  input logic       stream_done,
  input logic       last_of_run
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output request dropped while stalled");

  // a result is a token byte or a closing record, never both
  a_char_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(char_valid && token_done))
    else $error("token byte and token end in one result");

  // kind and status only travel with a token end
  a_kind_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind || token_status != 2'd0) |-> token_done)
    else $error("kind or status without token end");

  // buffer end closes the run of results for its byte
  a_sdone_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> last_of_run)
    else $error("stream end not on last result of run");

  // token end carries one of the defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_done |-> token_status != 2'd3)
    else $error("undefined token status");

endmodule

bind comment_skipping_tokenizer cst_checker u_cst_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .char_valid   (char_valid),
  .token_done   (token_done),
  .token_kind   (token_kind),
  .token_status (token_status),
  .stream_done  (stream_done),
  .last_of_run  (last_of_run)
);

>>> bench/tb_comment_skipping_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_comment_skipping_tokenizer: self-checking bench for the tokenizer
// feeds text bytes under random sender gaps and receiver stalls, predicts
// every token byte and end record in step with the design, checks in order
// ----------------------------------------------------------------------------
module tb_comment_skipping_tokenizer;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;    // cycles for a silent byte to clear the pipe
  localparam int HOLD_AFTER  = 60;   // bytes taken before the long receiver hold
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_ITEMS  = 30;   // no idling over the last part of the run
  localparam int PHASE_BYTES = 21;

  // one result of the design as seen on the output request
  typedef struct packed {
    logic [7:0]             ch;
    logic                   valid;
    logic                   done;
    cst_pkg::token_kind_t   kind;
    cst_pkg::token_status_t status;
    logic                   sdone;
    logic                   last;
  } tok_res_t;

  typedef enum logic [1:0] {
    STIM_BYTE,
    STIM_CAP,
    STIM_PAUSE
  } stim_kind_t;

  // one entry of the stimulus list; typed rows carry their result written out
  typedef struct packed {
    stim_kind_t kind;
    logic [7:0] data;
    logic [10:0] cap;
    logic       typed;
    tok_res_t   want;
  } stim_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [cst_pkg::CAP_W-1:0] cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                text_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [7:0]                token_char;
  logic                      char_valid;
  logic                      token_done;
  logic                      token_kind;
  logic [1:0]                token_status;
  logic                      stream_done;
  logic                      last_of_run;

  comment_skipping_tokenizer uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_char   (token_char),
    .char_valid   (char_valid),
    .token_done   (token_done),
    .token_kind   (token_kind),
    .token_status (token_status),
    .stream_done  (stream_done),
    .last_of_run  (last_of_run)
  );

  // parser state as the bench tracks it
  cst_pkg::scan_mode_t tk_mode;
  int                  tk_len;
  logic                tk_trunc;
  logic [10:0]         tk_cap;

  // results of the byte just parsed
  tok_res_t    step_res [0:2];
  int          step_cnt;

  tok_res_t    token_results_q [$];
  stim_t       text_plan [$];
  int          plan_bytes;
  int          bytes_taken;
  int          mismatches;
  int          cycles;
  bit          quiet_tail;
  bit          long_hold_done;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // cap in force: zero acts as one, anything past the maximum is clamped
  function automatic int active_cap();
    if (tk_cap == 11'd0) return 1;
    if (int'(tk_cap) > cst_pkg::TOKEN_CAP_MAX) return cst_pkg::TOKEN_CAP_MAX;
    return int'(tk_cap);
  endfunction

  function automatic void add_res(logic [7:0] ch, logic v, logic d,
                                  cst_pkg::token_kind_t k,
                                  cst_pkg::token_status_t s, logic sd);
    tok_res_t r;
    r.ch     = ch;
    r.valid  = v;
    r.done   = d;
    r.kind   = k;
    r.status = s;
    r.sdone  = sd;
    r.last   = 1'b0;
    if (step_cnt < 3) begin
      step_res[step_cnt] = r;
      step_cnt++;
    end
  endfunction

  // append one word byte; a word that reaches the cap is thrown away and
  // parsing stops until the buffer ends
  function automatic bit add_word_char(logic [7:0] ch);
    add_res(ch, 1'b1, 1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b0);
    tk_len++;
    if (tk_len >= active_cap()) begin
      add_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_DISCARD, 1'b1);
      tk_mode = cst_pkg::MODE_DRAIN;
      return 1'b1;
    end
    tk_mode = cst_pkg::MODE_WORD;
    return 1'b0;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    step_cnt = 0;
    case (tk_mode)
      cst_pkg::MODE_SKIP: begin
        if (b == cst_pkg::CH_NUL) begin
          add_res(8'h00, 1'b0, 1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1);
        end else if (b <= cst_pkg::CH_SPACE) begin
          // whitespace between tokens
        end else if (b == cst_pkg::CH_SLASH) begin
          tk_mode = cst_pkg::MODE_SLASH;
        end else if (b == cst_pkg::CH_QUOTE) begin
          tk_mode  = cst_pkg::MODE_STRING;
          tk_len   = 0;
          tk_trunc = 1'b0;
        end else begin
          tk_len   = 0;
          tk_trunc = 1'b0;
          void'(add_word_char(b));
        end
      end
      cst_pkg::MODE_SLASH: begin
        if (b == cst_pkg::CH_SLASH) begin
          tk_mode = cst_pkg::MODE_LINE;
        end else if (b == cst_pkg::CH_STAR) begin
          tk_mode = cst_pkg::MODE_BLOCK;
        end else begin
          // lone slash: it opens a word, this byte is handled as the next one
          tk_len   = 0;
          tk_trunc = 1'b0;
          if (add_word_char(cst_pkg::CH_SLASH)) begin
            if (b == cst_pkg::CH_NUL) tk_mode = cst_pkg::MODE_SKIP;
          end else if (b == cst_pkg::CH_NUL) begin
            add_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1);
            tk_mode = cst_pkg::MODE_SKIP;
          end else if (b <= cst_pkg::CH_SPACE) begin
            add_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b0);
            tk_mode = cst_pkg::MODE_SKIP;
          end else begin
            void'(add_word_char(b));
          end
        end
      end
      cst_pkg::MODE_LINE: begin
        if (b == cst_pkg::CH_NUL) begin
          add_res(8'h00, 1'b0, 1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1);
          tk_mode = cst_pkg::MODE_SKIP;
        end else if (b == cst_pkg::CH_NEWLINE) begin
          tk_mode = cst_pkg::MODE_SKIP;
        end
      end
      cst_pkg::MODE_BLOCK: begin
        if (b == cst_pkg::CH_NUL) begin
          add_res(8'h00, 1'b0, 1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1);
          tk_mode = cst_pkg::MODE_SKIP;
        end else if (b == cst_pkg::CH_STAR) begin
          tk_mode = cst_pkg::MODE_STAR;
        end
      end
      cst_pkg::MODE_STAR: begin
        if (b == cst_pkg::CH_NUL) begin
          add_res(8'h00, 1'b0, 1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1);
          tk_mode = cst_pkg::MODE_SKIP;
        end else if (b == cst_pkg::CH_SLASH) begin
          tk_mode = cst_pkg::MODE_SKIP;
        end else if (b != cst_pkg::CH_STAR) begin
          tk_mode = cst_pkg::MODE_BLOCK;
        end
      end
      cst_pkg::MODE_STRING: begin
        if (b == cst_pkg::CH_NUL || b == cst_pkg::CH_QUOTE) begin
          add_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_STRING,
                  tk_trunc ? cst_pkg::STATUS_TRUNC : cst_pkg::STATUS_OK,
                  b == cst_pkg::CH_NUL);
          tk_mode = cst_pkg::MODE_SKIP;
        end else if (tk_len < active_cap()) begin
          add_res(b, 1'b1, 1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b0);
          tk_len++;
        end else begin
          tk_trunc = 1'b1;   // string bytes past the cap are dropped
        end
      end
      cst_pkg::MODE_WORD: begin
        if (b == cst_pkg::CH_NUL) begin
          add_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1);
          tk_mode = cst_pkg::MODE_SKIP;
        end else if (b <= cst_pkg::CH_SPACE) begin
          add_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b0);
          tk_mode = cst_pkg::MODE_SKIP;
        end else begin
          void'(add_word_char(b));
        end
      end
      default: begin
        // draining a discarded buffer up to its zero byte
        if (b == cst_pkg::CH_NUL) tk_mode = cst_pkg::MODE_SKIP;
      end
    endcase
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus list
  function automatic tok_res_t end_rec(logic d, cst_pkg::token_kind_t k,
                                       cst_pkg::token_status_t s, logic sd);
    tok_res_t r;
    r.ch     = 8'h00;
    r.valid  = 1'b0;
    r.done   = d;
    r.kind   = k;
    r.status = s;
    r.sdone  = sd;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic push_item(stim_kind_t k, logic [7:0] b, logic [10:0] c, logic typed,
                           tok_res_t want);
    stim_t it;
    it.kind  = k;
    it.data  = b;
    it.cap   = c;
    it.typed = typed;
    it.want  = want;
    text_plan.push_back(it);
    if (k == STIM_BYTE) plan_bytes++;
  endtask

  task automatic push_byte(logic [7:0] b);
    push_item(STIM_BYTE, b, 11'd0, 1'b0, '0);
  endtask

  task automatic push_cap(logic [10:0] c);
    push_item(STIM_CAP, 8'h00, c, 1'b0, '0);
  endtask

  // random byte in lo..hi that is not the excluded value
  function automatic logic [7:0] rand_byte(int lo, int hi, logic [7:0] excl);
    logic [7:0] b;
    do b = 8'($urandom_range(lo, hi)); while (b == excl);
    return b;
  endfunction

  // token length: mostly short, now and then at or just past a cap under 40, else 7 to 40
  function automatic int rand_len(int lim);
    if ($urandom_range(0, 5) == 0)
      return (lim < 40) ? lim + $urandom_range(0, 2) : $urandom_range(7, 40);
    return $urandom_range(1, 6);
  endfunction

  // one well-formed or broken piece of text, often followed by a separator
  task automatic add_segment(int lim);
    int sel;
    int n;
    sel = $urandom_range(0, 15);
    if (sel <= 4 || sel == 12) begin
      // word, sometimes led by a lone slash
      n = rand_len(lim);
      if (sel == 12) push_byte(cst_pkg::CH_SLASH);
      for (int i = (sel == 12) ? 1 : 0; i < n; i++) begin
        if (i == 0 || (sel == 12 && i == 1)) push_byte(8'($urandom_range(48, 255)));
        else push_byte(8'($urandom_range(33, 255)));
      end
      // a discarded word drains until the buffer ends, so end it right away
      if (n >= lim) push_byte(cst_pkg::CH_NUL);
      else if ($urandom_range(0, 4) == 0) push_byte(cst_pkg::CH_NUL);
      else push_byte(8'($urandom_range(1, 32)));
    end else begin
      if (sel <= 7) begin
        n = rand_len(lim);
        push_byte(cst_pkg::CH_QUOTE);
        repeat (n) push_byte(rand_byte(1, 255, cst_pkg::CH_QUOTE));
        push_byte(($urandom_range(0, 5) == 0) ? cst_pkg::CH_NUL : cst_pkg::CH_QUOTE);
      end else if (sel <= 9) begin
        push_byte(cst_pkg::CH_SLASH);
        push_byte(cst_pkg::CH_SLASH);
        repeat ($urandom_range(0, 6)) push_byte(rand_byte(1, 255, cst_pkg::CH_NEWLINE));
        push_byte(cst_pkg::CH_NEWLINE);
      end else if (sel <= 11) begin
        push_byte(cst_pkg::CH_SLASH);
        push_byte(cst_pkg::CH_STAR);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 2) == 0) push_byte(cst_pkg::CH_STAR);
          else push_byte(rand_byte(1, 255, cst_pkg::CH_SLASH));
        end
        push_byte(cst_pkg::CH_STAR);
        push_byte(cst_pkg::CH_SLASH);
      end else if (sel == 13) begin
        push_byte(cst_pkg::CH_NUL);
      end else if (sel == 14) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        // opened comment or string cut off by the buffer end
        n = $urandom_range(0, 2);
        if (n == 0) begin
          push_byte(cst_pkg::CH_SLASH);
          push_byte(cst_pkg::CH_STAR);
        end else if (n == 1) begin
          push_byte(cst_pkg::CH_SLASH);
          push_byte(cst_pkg::CH_SLASH);
        end else begin
          push_byte(cst_pkg::CH_QUOTE);
        end
        repeat ($urandom_range(0, 4)) push_byte(rand_byte(1, 255, cst_pkg::CH_STAR));
        push_byte(cst_pkg::CH_NUL);
      end
      if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(1, 32)));
    end
  endtask

  task automatic build_plan();
    logic [10:0] phase_caps [0:7];
    int          lim;
    int          start;
    phase_caps = '{11'd2047, 11'd1, 11'd3, 11'd8, 11'd1024, 11'd0, 11'd5, 11'd2};
    phase_caps[4] = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'($urandom_range(9, 40));

    // directed rows, cap at its reset value
    push_item(STIM_BYTE, cst_pkg::CH_NUL, 11'd0, 1'b1,
              end_rec(1'b0, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b1));
    push_byte(cst_pkg::CH_SPACE);
    push_byte(8'hff);                     // top byte values count as word bytes
    push_item(STIM_BYTE, 8'h01, 11'd0, 1'b1,
              end_rec(1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b0));
    push_byte(cst_pkg::CH_SLASH);         // line comment
    push_byte(cst_pkg::CH_SLASH);
    push_byte(cst_pkg::CH_NEWLINE);
    push_byte(cst_pkg::CH_SLASH);         // block comment with a star run
    push_byte(cst_pkg::CH_STAR);
    push_byte(cst_pkg::CH_STAR);
    push_byte("A");
    push_byte(cst_pkg::CH_STAR);
    push_byte(cst_pkg::CH_SLASH);
    push_byte(cst_pkg::CH_SLASH);         // lone slash opens a word
    push_byte("b");
    push_item(STIM_BYTE, cst_pkg::CH_SPACE, 11'd0, 1'b1,
              end_rec(1'b1, cst_pkg::KIND_WORD, cst_pkg::STATUS_OK, 1'b0));
    push_byte(cst_pkg::CH_QUOTE);         // string cut by the buffer end
    push_byte(8'h7f);
    push_item(STIM_BYTE, cst_pkg::CH_NUL, 11'd0, 1'b1,
              end_rec(1'b1, cst_pkg::KIND_STRING, cst_pkg::STATUS_OK, 1'b1));
    // zero cap acts as one: a one-byte word is discarded, a string truncated
    push_cap(11'd0);
    push_byte("w");
    push_byte("z");
    push_byte(cst_pkg::CH_NUL);
    push_byte(cst_pkg::CH_QUOTE);
    push_byte("a");
    push_byte("b");
    push_item(STIM_BYTE, cst_pkg::CH_QUOTE, 11'd0, 1'b1,
              end_rec(1'b1, cst_pkg::KIND_STRING, cst_pkg::STATUS_TRUNC, 1'b0));

    // random phases, one cap setting each
    foreach (phase_caps[p]) begin
      push_cap(phase_caps[p]);
      lim = (phase_caps[p] == 11'd0) ? 1 :
            (int'(phase_caps[p]) > cst_pkg::TOKEN_CAP_MAX) ? cst_pkg::TOKEN_CAP_MAX :
            int'(phase_caps[p]);
      start = plan_bytes;
      while (plan_bytes - start < PHASE_BYTES) begin
        add_segment(lim);
        if (p == 2 && plan_bytes - start >= PHASE_BYTES / 2 &&
            text_plan[$].kind == STIM_BYTE && $urandom_range(0, 3) == 0)
          push_item(STIM_PAUSE, 8'h00, 11'd0, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------- sender
  task automatic send_text(stim_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= it.data;
    do @(posedge clk); while (in_stall);
    // byte taken at this edge: its results show from the next cycle on
    tokenize_byte(it.data);
    if (it.typed) begin
      token_results_q.push_back(it.want);
    end else begin
      for (int i = 0; i < step_cnt; i++) token_results_q.push_back(step_res[i]);
    end
    bytes_taken++;
  endtask

  // wait until every result is out and the parser is idle, then maybe load the cap
  task automatic settle_and_load(stim_t it);
    in_valid <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (it.kind == STIM_CAP) begin
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= it.cap;
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      tk_cap = it.cap;
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    text_byte   <= 8'h00;
    mismatches  = 0;
    bytes_taken = 0;
    plan_bytes  = 0;
    quiet_tail  = 1'b0;
    tk_mode     = cst_pkg::MODE_SKIP;
    tk_len      = 0;
    tk_trunc    = 1'b0;
    tk_cap      = cst_pkg::TOKEN_CAP_RESET;
    build_plan();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (text_plan[i]) begin
      if (i >= text_plan.size() - TAIL_ITEMS) quiet_tail = 1'b1;
      if (text_plan[i].kind == STIM_BYTE) send_text(text_plan[i]);
      else settle_and_load(text_plan[i]);
    end
    in_valid <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("comment_skipping_tokenizer: match");
    end else begin
      $display("comment_skipping_tokenizer: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // random stall bursts, plus one long hold that backs the design up until
  // it stalls its input while the sender keeps offering bytes
  initial begin
    out_stall <= 1'b0;
    long_hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!long_hold_done && bytes_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checker
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    tok_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (token_results_q.size() == 0) begin
        $display("%0t: expected no result, got char %0h valid %0b done %0b sdone %0b",
                 $time, token_char, char_valid, token_done, stream_done);
        mismatches++;
      end else begin
        want = token_results_q.pop_front();
        check_field("token_char", want.ch, token_char);
        check_field("char_valid", want.valid, char_valid);
        check_field("token_done", want.done, token_done);
        check_field("token_kind", want.kind, token_kind);
        check_field("token_status", want.status, token_status);
        check_field("stream_done", want.sdone, stream_done);
        check_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("comment_skipping_tokenizer: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/core/cst_pkg.sv
rtl/core/comment_skipping_tokenizer.sv
rtl/core/cst_checker.sv
bench/tb_comment_skipping_tokenizer.sv
